### hw/rtl/dts_pkg.sv
// Package for the depth-first topological sort block.
// Holds request codes, status codes, controller states and command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dts_pkg;

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_RUN   = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_ADD,
		S_RUN_INIT,
		S_ROOT,
		S_PUSH,
		S_TOP,
		S_EDGE,
		S_HEAD,
		S_TEST,
		S_EMIT,
		S_EMIT_WAIT,
		S_STAT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic add_step;
		logic run_init;
		logic root_step;
		logic push_root;
		logic top_read;
		logic edge_read;
		logic head_read;
		logic test_step;
		logic emit_load;
		logic stat_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic root_done;
		logic root_push;
		logic sp_empty;
		logic edge_end;
		logic emit_done;
	} sts_t;

endpackage
`default_nettype wire

### hw/rtl/dts_ctrl.sv
// Controller state machine for the topological sort block.
// Depends on dts_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none
module dts_ctrl
	import dts_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_fire,
	input  wire logic [1:0] in_req,
	input  wire logic       out_free,
	input  wire sts_t       sts,
	output cmd_t            cmd,
	output logic            busy
);

	state_t state_q, state_d;
	logic   boot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end

	// The sweep after reset returns to idle without a status word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) boot_q <= 1'b1;
		else if (state_q == S_CLR && sts.clr_done) boot_q <= 1'b0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					unique case (req_t'(in_req))
						REQ_ADD:   state_d = S_ADD;
						REQ_RUN:   state_d = S_RUN_INIT;
						REQ_CLEAR: state_d = S_CLR;
						REQ_NONE:  state_d = S_STAT;
						default:   state_d = S_STAT;
					endcase
				end
			end
			S_CLR:       if (sts.clr_done) state_d = boot_q ? S_IDLE : S_STAT;
			S_ADD:       state_d = S_STAT;
			S_STAT:      if (out_free) state_d = S_IDLE;
			S_RUN_INIT:  state_d = S_ROOT;
			S_ROOT: begin
				if (sts.root_done) state_d = S_EMIT;
				else if (sts.root_push) state_d = S_PUSH;
			end
			S_PUSH:      state_d = S_TOP;
			S_TOP: begin
				if (sts.sp_empty) state_d = S_ROOT;
				else state_d = S_EDGE;
			end
			S_EDGE:      state_d = sts.edge_end ? S_TOP : S_HEAD;
			S_HEAD:      state_d = S_TEST;
			S_TEST:      state_d = S_TOP;
			S_EMIT:      if (out_free) state_d = S_EMIT_WAIT;
			S_EMIT_WAIT: state_d = sts.emit_done ? S_IDLE : S_EMIT;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE:      busy = 1'b0;
			S_CLR:       cmd.clr_step = 1'b1;
			S_ADD:       cmd.add_step = 1'b1;
			S_STAT:      cmd.stat_load = out_free;
			S_RUN_INIT:  cmd.run_init = 1'b1;
			S_ROOT:      cmd.root_step = 1'b1;
			S_PUSH:      cmd.push_root = 1'b1;
			S_TOP:       cmd.top_read = 1'b1;
			S_EDGE:      cmd.edge_read = 1'b1;
			S_HEAD:      cmd.head_read = 1'b1;
			S_TEST:      cmd.test_step = 1'b1;
			S_EMIT:      cmd.emit_load = out_free;
			S_EMIT_WAIT: ;
			default:     ;
		endcase
	end

endmodule
`default_nettype wire

### hw/rtl/dts_dp.sv
// Datapath of the topological sort block: edge store, list heads and tails,
// visited marks, search stack, order buffer and the output register.
// Depends on dts_pkg; controlled by dts_ctrl through cmd_t and sts_t.
`timescale 1ns / 1ps
`default_nettype none
module dts_dp
	import dts_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_fire,
	input  wire logic [1:0] in_req,
	input  wire logic [5:0] in_src,
	input  wire logic [5:0] in_dst,
	input  wire logic [6:0] cfg_data,
	input  wire logic       cfg_fire,
	input  cmd_t            cmd,
	output sts_t            sts,
	input  wire logic       out_take,
	output logic            out_valid,
	output logic [9:0]      out_word
);

	localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int SW = $clog2(MAX_EDGES + 1);

	logic [6:0]    ncfg_q;
	logic [CW-1:0] n_act;

	logic [5:0] tgt_mem [MAX_EDGES];
	logic [EW:0] lnk_mem [MAX_EDGES];
	logic [EW:0] head_mem [MAX_NODES];
	logic [EW-1:0] tail_mem [MAX_NODES];
	logic [NW-1:0] stk_node [MAX_NODES];
	logic [EW:0] stk_edge [MAX_NODES];
	logic [NW-1:0] ord_mem [MAX_NODES];
	logic [MAX_NODES-1:0] vis_q;

	logic [SW-1:0] stored_q;
	logic [NW-1:0] clr_q;
	logic [1:0]    req_q;
	logic [5:0]    src_q, dst_q;
	logic [CW-1:0] root_q, pos_q, sp_q, emit_q;
	logic [NW-1:0] top_node_q;
	logic [EW:0]   top_edge_q, link_q;
	logic [5:0]    tgt_q;
	logic [EW:0]   head_rd_q;
	logic [EW-1:0] tail_rd_q;
	logic [1:0]    status_q;

	logic [NW-1:0] top_idx;
	logic [NW-1:0] head_addr;
	logic          src_bad, dst_bad, full;
	logic [1:0]    add_status;
	logic [NW-1:0] src_i;
	logic          head_null;
	logic          push_ok;

	// Node count clamped to 1..MAX_NODES.
	always_comb begin
		if (ncfg_q == 7'd0) n_act = CW'(1);
		else if (32'(ncfg_q) > MAX_NODES) n_act = CW'(MAX_NODES);
		else n_act = CW'(ncfg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ncfg_q <= 7'd64;
		else if (cfg_fire) ncfg_q <= cfg_data;
	end

	assign top_idx = NW'(sp_q - CW'(1));
	assign src_i = NW'(src_q);
	assign head_addr = cmd.head_read ? NW'(tgt_q) : (cmd.root_step ? NW'(root_q) : NW'(in_src));
	assign src_bad = ({1'b0, src_q} >= 7'(n_act)) || (32'(src_q) >= MAX_NODES);
	assign dst_bad = ({1'b0, dst_q} >= 7'(n_act)) || (32'(dst_q) >= MAX_NODES);
	assign full = (stored_q >= SW'(MAX_EDGES));
	assign head_null = head_rd_q[EW];
	assign push_ok = ({1'b0, tgt_q} < 7'(n_act)) && !vis_q[NW'(tgt_q)]
		&& (sp_q < CW'(MAX_NODES));

	always_comb begin
		if (src_bad || dst_bad) add_status = ST_RANGE;
		else if (full) add_status = ST_FULL;
		else add_status = ST_OK;
	end

	assign sts.clr_done = (32'(clr_q) == MAX_NODES - 1);
	assign sts.root_done = (root_q >= n_act);
	assign sts.root_push = !vis_q[NW'(root_q)];
	assign sts.sp_empty = (sp_q == '0);
	assign sts.edge_end = top_edge_q[EW];
	assign sts.emit_done = (emit_q == n_act);

	always_ff @(posedge clk) begin
		head_rd_q <= head_mem[head_addr];
		if (in_fire) begin
			req_q <= in_req;
			src_q <= in_src;
			dst_q <= in_dst;
			tail_rd_q <= tail_mem[NW'(in_src)];
		end
		if (cmd.clr_step) head_mem[clr_q] <= {1'b1, {EW{1'b0}}};
		if (cmd.add_step) begin
			status_q <= add_status;
			if (add_status == ST_OK) begin
				tgt_mem[EW'(stored_q)] <= dst_q;
				lnk_mem[EW'(stored_q)] <= {1'b1, {EW{1'b0}}};
				if (head_null) head_mem[src_i] <= {1'b0, EW'(stored_q)};
				else lnk_mem[tail_rd_q] <= {1'b0, EW'(stored_q)};
				tail_mem[src_i] <= EW'(stored_q);
			end
		end
		if (cmd.push_root) begin
			stk_node[0] <= NW'(root_q);
			stk_edge[0] <= head_rd_q;
		end
		if (cmd.top_read) begin
			top_node_q <= stk_node[top_idx];
			top_edge_q <= stk_edge[top_idx];
		end
		if (cmd.edge_read) begin
			if (top_edge_q[EW]) begin
				if (pos_q != '0) ord_mem[NW'(pos_q - CW'(1))] <= top_node_q;
			end else begin
				tgt_q <= tgt_mem[EW'(top_edge_q)];
				link_q <= lnk_mem[EW'(top_edge_q)];
			end
		end
		if (cmd.head_read) stk_edge[top_idx] <= link_q;
		if (cmd.test_step && push_ok) begin
			stk_node[NW'(sp_q)] <= NW'(tgt_q);
			stk_edge[NW'(sp_q)] <= head_rd_q;
		end
		if (cmd.emit_load)
			out_word <= {(emit_q + CW'(1) == n_act), 1'b1, ST_OK, 6'(ord_mem[NW'(emit_q)])};
		if (cmd.stat_load) begin
			if (req_t'(req_q) == REQ_ADD) out_word <= {1'b1, 1'b0, status_q, 6'd0};
			else out_word <= {1'b1, 1'b0, ST_OK, 6'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			clr_q <= '0;
			vis_q <= '0;
			root_q <= '0;
			pos_q <= '0;
			sp_q <= '0;
			emit_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= sts.clr_done ? '0 : clr_q + NW'(1);
				stored_q <= '0;
			end
			if (cmd.add_step && add_status == ST_OK) stored_q <= stored_q + SW'(1);
			if (cmd.run_init) begin
				vis_q <= '0;
				root_q <= '0;
				pos_q <= n_act;
				sp_q <= '0;
				emit_q <= '0;
			end
			if (cmd.root_step && !sts.root_done && !sts.root_push) root_q <= root_q + CW'(1);
			if (cmd.push_root) begin
				vis_q[NW'(root_q)] <= 1'b1;
				sp_q <= CW'(1);
				root_q <= root_q + CW'(1);
			end
			if (cmd.edge_read && top_edge_q[EW]) begin
				if (pos_q != '0) pos_q <= pos_q - CW'(1);
				sp_q <= sp_q - CW'(1);
			end
			if (cmd.test_step && push_ok) begin
				vis_q[NW'(tgt_q)] <= 1'b1;
				sp_q <= sp_q + CW'(1);
			end
			if (cmd.emit_load) emit_q <= emit_q + CW'(1);
			if (cmd.emit_load || cmd.stat_load) out_valid <= 1'b1;
			else if (out_take) out_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/dfs_topological_sort.sv
// Top level of the depth-first topological sort block.
// Depends on dts_pkg, dts_ctrl and dts_dp.
//
// A request word is taken only while the block is idle. An add edge request reads a
// list head and tail as the word is accepted, updates the store, then loads the status
// word; a status-only request goes straight to the status word. A clear first sweeps
// the list heads, and the same sweep runs after reset before the first word is taken.
// A run tests each root candidate, pushes each unvisited one to start a search, walks
// each edge by stack top, edge store and head reads and a visit test, pops each node
// into the order buffer as it finishes, then streams node_count words; heads, edges
// and stack are read through registers, and a stalled output holds the stream.
`timescale 1ns / 1ps
`default_nettype none
module dfs_topological_sort
	import dts_pkg::*;
#(
	parameter int MAX_NODES = 64,
	parameter int MAX_EDGES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // src_node[5:0], dst_node[11:6], zero[15:12]
	input  wire logic [1:0]  s_tuser,  // req_type[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // order_node[5:0], status[7:6]
	output logic             m_tuser,  // is_order[0]
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic busy, in_fire, out_free, out_valid;
	logic [9:0] out_word;

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	assign cfg_ready = !busy;
	assign out_free = !out_valid || m_tready;
	assign m_tvalid = out_valid;
	assign m_tdata = out_word[7:0];
	assign m_tuser = out_word[8];
	assign m_tlast = out_word[9];

	dts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_req(s_tuser),
		.out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy)
	);

	dts_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_req(s_tuser),
		.in_src(s_tdata[5:0]), .in_dst(s_tdata[11:6]), .cfg_data(cfg_data),
		.cfg_fire(cfg_valid && cfg_ready), .cmd(cmd), .sts(sts),
		.out_take(m_tready), .out_valid(out_valid), .out_word(out_word)
	);

endmodule
`default_nettype wire

### hw/rtl/dts_checker.sv
// Port checker for the topological sort block, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module dts_assert (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tuser,
	input wire logic       m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable({m_tlast, m_tuser, m_tdata}))
		else $error("Output word changed while stalled.");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:6] == 2'd0)
		else $error("Order word carries a nonzero status.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input accepted while a word is still in work.");

	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[5:0] == 6'd0)
		else $error("Status word without last flag.");

endmodule

bind dfs_topological_sort dts_assert u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
	.m_tlast(m_tlast)
);
`default_nettype wire
